// ===== rtl/mgrs_pkg.sv =====
package mgrs_pkg;

  localparam int MAX_ITEMS = 1024;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int VAL_W     = 31;
  localparam int RADIX     = 10;
  localparam int DIG_W     = 4;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int RECIP_SH  = 34;
  localparam logic [VAL_W-1:0] RECIP = VAL_W'(32'h6666_6667);

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             last;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0] max_gap;
    logic             overflow;
  } out_t;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic              last;
    logic              store;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  n;
    logic              ovf;
  } cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] quot;
  } ent_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_CRD,
    S_CMUL,
    S_CDIG,
    S_PFX,
    S_SRD,
    S_SMUL,
    S_SDIG,
    S_GRD,
    S_GDAT,
    S_DONE
  } state_t;

endpackage

// ===== rtl/max_adjacent_gap_radix_sort.sv =====
// channel   signals                       transaction when
// input     push, full, item              push && !full
// result    empty, pop, result            pop && !empty
//
// Values load at one per cycle through a two-entry queue into a RAM.
// After the last value each decimal digit pass counts, prefix-sums and scatters the
// n values, bound by the single read port of the source RAM; then the gap scan runs.
// Passes run until every remaining quotient is zero.
// Reset clears control only; no clearing pass runs.
// Input stalls once the queue fills while a set is sorted; result stalls hold.
module max_adjacent_gap_radix_sort (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  mgrs_pkg::in_t   item,
  output logic            empty,
  input  logic            pop,
  output mgrs_pkg::out_t  result
);

  mgrs_pkg::cmd_t cmd_in, cmd_out;
  logic           q_push, q_full, q_empty, q_pop;

  assign full = q_full;

  mgrs_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .q_full (q_full),
    .q_push (q_push),
    .cmd    (cmd_in)
  );

  mgrs_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wdata (cmd_in),
    .full  (q_full),
    .rd    (q_pop),
    .rdata (cmd_out),
    .empty (q_empty)
  );

  mgrs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_out),
    .cmd_empty (q_empty),
    .cmd_pop   (q_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

// ===== rtl/mgrs_ram.sv =====
module mgrs_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mgrs_front.sv =====
module mgrs_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mgrs_pkg::in_t     item,
  input  logic              q_full,
  output logic              q_push,
  output mgrs_pkg::cmd_t    cmd
);

  logic [mgrs_pkg::CNT_W-1:0] count;
  logic                       ovf;
  logic                       store;

  assign store  = (count < mgrs_pkg::CNT_W'(mgrs_pkg::MAX_ITEMS));
  assign q_push = push && !q_full;

  always_comb begin
    cmd.value = item.value;
    cmd.last  = item.last;
    cmd.store = store;
    cmd.addr  = count[mgrs_pkg::ADDR_W-1:0];
    cmd.n     = store ? count + mgrs_pkg::CNT_W'(1) : count;
    cmd.ovf   = ovf || !store;
  end

  // classify each transaction: keep it or drop it past capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (q_push) begin
      if (item.last) begin
        count <= '0;
        ovf   <= 1'b0;
      end else begin
        count <= cmd.n;
        ovf   <= cmd.ovf;
      end
    end
  end

endmodule

// ===== rtl/mgrs_fifo.sv =====
module mgrs_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  mgrs_pkg::cmd_t  wdata,
  output logic            full,
  input  logic            rd,
  output mgrs_pkg::cmd_t  rdata,
  output logic            empty
);

  mgrs_pkg::cmd_t slot [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign rdata = slot[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      slot[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= '0;
    end else begin
      if (wr && !full) begin
        wptr <= ~wptr;
      end
      if (rd && !empty) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + 2'((wr && !full) ? 1 : 0) - 2'((rd && !empty) ? 1 : 0);
    end
  end

endmodule

// ===== rtl/mgrs_back.sv =====
module mgrs_back (
  input  logic            clk,
  input  logic            rst,
  input  mgrs_pkg::cmd_t  cmd,
  input  logic            cmd_empty,
  output logic            cmd_pop,
  output mgrs_pkg::out_t  result,
  output logic            empty,
  input  logic            pop
);

  mgrs_pkg::state_t            state, state_next;
  logic                        sel, sel_next;
  logic [mgrs_pkg::CNT_W-1:0]  n, n_next;
  logic                        ovf_r, ovf_r_next;
  logic [mgrs_pkg::CNT_W-1:0]  i, i_next;
  logic [mgrs_pkg::DIG_W-1:0]  j, j_next;
  logic [mgrs_pkg::CNT_W-1:0]  counts [mgrs_pkg::RADIX];
  logic [mgrs_pkg::CNT_W-1:0]  counts_next [mgrs_pkg::RADIX];
  logic [mgrs_pkg::VAL_W-1:0]  q_r, q_r_next;
  logic [mgrs_pkg::VAL_W-1:0]  v_r, v_r_next;
  logic [mgrs_pkg::PROD_W-1:0] prod, prod_next;
  logic                        nz, nz_next;
  logic [mgrs_pkg::VAL_W-1:0]  gap, gap_next;
  logic [mgrs_pkg::VAL_W-1:0]  prev, prev_next;
  logic                        res_valid, res_valid_next;
  mgrs_pkg::out_t              res, res_next;

  mgrs_pkg::ent_t              rd_a, rd_b, rd_src, wdata;
  logic [mgrs_pkg::ADDR_W-1:0] waddr, raddr;
  logic                        load_we, scat_we;
  logic [mgrs_pkg::VAL_W-1:0]  qd, rem, diff;
  logic [mgrs_pkg::DIG_W-1:0]  dig;
  logic [mgrs_pkg::CNT_W-1:0]  pos;

  assign rd_src = sel ? rd_b : rd_a;
  assign raddr  = i[mgrs_pkg::ADDR_W-1:0];
  assign qd     = mgrs_pkg::VAL_W'(prod[mgrs_pkg::PROD_W-1:mgrs_pkg::RECIP_SH]);
  assign rem    = q_r - {qd[mgrs_pkg::VAL_W-4:0], 3'b000} - {qd[mgrs_pkg::VAL_W-2:0], 1'b0};
  assign dig    = rem[mgrs_pkg::DIG_W-1:0];
  assign pos    = counts[dig] - mgrs_pkg::CNT_W'(1);
  assign diff   = rd_src.value - prev;
  assign empty  = !res_valid;
  assign result = res;

  mgrs_ram #(.W($bits(mgrs_pkg::ent_t)), .DEPTH(mgrs_pkg::MAX_ITEMS)) u_ram_a (
    .clk   (clk),
    .we    ((load_we && !sel) || (scat_we && sel)),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_a)
  );

  mgrs_ram #(.W($bits(mgrs_pkg::ent_t)), .DEPTH(mgrs_pkg::MAX_ITEMS)) u_ram_b (
    .clk   (clk),
    .we    ((load_we && sel) || (scat_we && !sel)),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_b)
  );

  always_comb begin
    state_next     = state;
    sel_next       = sel;
    n_next         = n;
    ovf_r_next     = ovf_r;
    i_next         = i;
    j_next         = j;
    counts_next    = counts;
    q_r_next       = q_r;
    v_r_next       = v_r;
    prod_next      = prod;
    nz_next        = nz;
    gap_next       = gap;
    prev_next      = prev;
    res_valid_next = res_valid;
    res_next       = res;
    cmd_pop        = 1'b0;
    load_we        = 1'b0;
    scat_we        = 1'b0;
    waddr          = cmd.addr;
    wdata          = '{value: cmd.value, quot: cmd.value};

    if (pop && res_valid) begin
      res_valid_next = 1'b0;
    end

    case (state)
      mgrs_pkg::S_LOAD: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          load_we = cmd.store;
          nz_next = nz || (cmd.store && (cmd.value != '0));
          if (cmd.last) begin
            n_next     = cmd.n;
            ovf_r_next = cmd.ovf;
            i_next     = '0;
            gap_next   = '0;
            for (int k = 0; k < mgrs_pkg::RADIX; k++) begin
              counts_next[k] = '0;
            end
            state_next = nz_next ? mgrs_pkg::S_CRD : mgrs_pkg::S_GRD;
            nz_next    = 1'b0;
          end
        end
      end
      mgrs_pkg::S_CRD: begin
        state_next = mgrs_pkg::S_CMUL;
      end
      mgrs_pkg::S_CMUL: begin
        q_r_next   = rd_src.quot;
        v_r_next   = rd_src.value;
        prod_next  = mgrs_pkg::PROD_W'(rd_src.quot) * mgrs_pkg::PROD_W'(mgrs_pkg::RECIP);
        state_next = mgrs_pkg::S_CDIG;
      end
      mgrs_pkg::S_CDIG: begin
        counts_next[dig] = counts[dig] + mgrs_pkg::CNT_W'(1);
        if (i == n - mgrs_pkg::CNT_W'(1)) begin
          j_next     = mgrs_pkg::DIG_W'(1);
          state_next = mgrs_pkg::S_PFX;
        end else begin
          i_next     = i + mgrs_pkg::CNT_W'(1);
          state_next = mgrs_pkg::S_CRD;
        end
      end
      mgrs_pkg::S_PFX: begin
        counts_next[j] = counts[j] + counts[j - mgrs_pkg::DIG_W'(1)];
        if (j == mgrs_pkg::DIG_W'(mgrs_pkg::RADIX - 1)) begin
          i_next     = n - mgrs_pkg::CNT_W'(1);
          state_next = mgrs_pkg::S_SRD;
        end else begin
          j_next = j + mgrs_pkg::DIG_W'(1);
        end
      end
      mgrs_pkg::S_SRD: begin
        state_next = mgrs_pkg::S_SMUL;
      end
      mgrs_pkg::S_SMUL: begin
        q_r_next   = rd_src.quot;
        v_r_next   = rd_src.value;
        prod_next  = mgrs_pkg::PROD_W'(rd_src.quot) * mgrs_pkg::PROD_W'(mgrs_pkg::RECIP);
        state_next = mgrs_pkg::S_SDIG;
      end
      mgrs_pkg::S_SDIG: begin
        counts_next[dig] = pos;
        scat_we          = 1'b1;
        waddr            = pos[mgrs_pkg::ADDR_W-1:0];
        wdata            = '{value: v_r, quot: qd};
        nz_next          = nz || (qd != '0);
        if (i == '0) begin
          sel_next = ~sel;
          if (nz_next) begin
            for (int k = 0; k < mgrs_pkg::RADIX; k++) begin
              counts_next[k] = '0;
            end
            state_next = mgrs_pkg::S_CRD;
          end else begin
            state_next = mgrs_pkg::S_GRD;
          end
          nz_next = 1'b0;
        end else begin
          i_next     = i - mgrs_pkg::CNT_W'(1);
          state_next = mgrs_pkg::S_SRD;
        end
      end
      mgrs_pkg::S_GRD: begin
        state_next = mgrs_pkg::S_GDAT;
      end
      mgrs_pkg::S_GDAT: begin
        if ((i != '0) && (diff > gap)) begin
          gap_next = diff;
        end
        prev_next = rd_src.value;
        if (i == n - mgrs_pkg::CNT_W'(1)) begin
          state_next = mgrs_pkg::S_DONE;
        end else begin
          i_next     = i + mgrs_pkg::CNT_W'(1);
          state_next = mgrs_pkg::S_GRD;
        end
      end
      mgrs_pkg::S_DONE: begin
        if (!res_valid) begin
          res_next       = '{max_gap: gap, overflow: ovf_r};
          res_valid_next = 1'b1;
          state_next     = mgrs_pkg::S_LOAD;
        end
      end
      default: begin
        state_next = mgrs_pkg::S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mgrs_pkg::S_LOAD;
      sel       <= 1'b0;
      nz        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sel       <= sel_next;
      nz        <= nz_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    n      <= n_next;
    ovf_r  <= ovf_r_next;
    i      <= i_next;
    j      <= j_next;
    counts <= counts_next;
    q_r    <= q_r_next;
    v_r    <= v_r_next;
    prod   <= prod_next;
    gap    <= gap_next;
    prev   <= prev_next;
    res    <= res_next;
  end

endmodule

// ===== rtl/mgrs_chk.sv =====
module mgrs_chk (
  input logic           clk,
  input logic           rst,
  input logic           full,
  input logic           empty,
  input logic           pop,
  input mgrs_pkg::out_t result
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("result dropped before pop");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(result))
    else $error("result changed while stalled");

  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result present after reset");

  a_rst_full: assert property (@(posedge clk) rst |=> !full)
    else $error("input blocked after reset");

endmodule

bind max_adjacent_gap_radix_sort mgrs_chk u_chk (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

// ===== sim/mgrs_checker.sv =====
`timescale 1ns / 100ps

module mgrs_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic           full,
  input  mgrs_pkg::in_t  item,
  input  logic           empty,
  input  logic           pop,
  input  mgrs_pkg::out_t result,
  output int             fail_count,
  output int             pending
);

  logic [mgrs_pkg::VAL_W-1:0] set_vals[$];
  logic                       set_ovf;
  mgrs_pkg::out_t             gap_queue[$];

  function automatic mgrs_pkg::out_t predict_gap(
    input logic [mgrs_pkg::VAL_W-1:0] vals[$],
    input logic                       ovf
  );
    mgrs_pkg::out_t r;
    logic [mgrs_pkg::VAL_W-1:0] sorted[$];
    logic [mgrs_pkg::VAL_W-1:0] best;
    best = '0;
    sorted = vals;
    sorted.sort();
    for (int i = 0; i + 1 < sorted.size(); i++)
      if (sorted[i+1] - sorted[i] > best) best = sorted[i+1] - sorted[i];
    r.max_gap = best;
    r.overflow = ovf;
    return r;
  endfunction

  always @(posedge clk) begin
    mgrs_pkg::out_t want;
    if (rst) begin
      fail_count = 0;
      set_ovf = 1'b0;
      set_vals.delete();
      gap_queue.delete();
    end else begin
      if (push && !full) begin
        if (set_vals.size() < mgrs_pkg::MAX_ITEMS) set_vals.push_back(item.value);
        else set_ovf = 1'b1;
        if (item.last) begin
          gap_queue.push_back(predict_gap(set_vals, set_ovf));
          set_vals.delete();
          set_ovf = 1'b0;
        end
      end
      if (pop && !empty) begin
        if (gap_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected transaction: gap %0d ovf %0d", result.max_gap,
                     result.overflow);
        end else begin
          want = gap_queue.pop_front();
          if (want.max_gap !== result.max_gap || want.overflow !== result.overflow) begin
            fail_count++;
            if (fail_count <= 10)
              $display("gap exp %0d act %0d, ovf exp %0d act %0d", want.max_gap,
                       result.max_gap, want.overflow, result.overflow);
          end
        end
      end
    end
    pending = gap_queue.size();
  end
endmodule

// ===== sim/tb_max_adjacent_gap_radix_sort.sv =====
`timescale 1ns / 100ps

module tb_max_adjacent_gap_radix_sort;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           push = 1'b0;
  logic           pop = 1'b0;
  mgrs_pkg::in_t  item = '0;
  logic           full, empty;
  mgrs_pkg::out_t result;
  int             fail_count, pending;
  bit             calm = 1'b0;

  always #6 clk = ~clk;

  max_adjacent_gap_radix_sort u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result)
  );

  mgrs_checker u_chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic logic [mgrs_pkg::VAL_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return {mgrs_pkg::VAL_W{1'b1}} - mgrs_pkg::VAL_W'($urandom_range(0, 3));
      2: return mgrs_pkg::VAL_W'($urandom_range(0, 99));
      3: return mgrs_pkg::VAL_W'($urandom_range(0, 99999));
      default: return mgrs_pkg::VAL_W'($urandom);
    endcase
  endfunction

  task automatic send(input logic [mgrs_pkg::VAL_W-1:0] v, input logic lst);
    while (!calm && $urandom_range(0, 99) < 22) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= '{value: v, last: lst};
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_set(input int n);
    for (int i = 0; i < n; i++) send(rand_value(), i == n - 1);
  endtask

  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= calm || ($urandom_range(0, 99) >= 22);
  end

  initial begin
    int sent;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send(mgrs_pkg::VAL_W'(5), 1'b1);
    send('0, 1'b0); send({mgrs_pkg::VAL_W{1'b1}}, 1'b1);
    send(mgrs_pkg::VAL_W'(7), 1'b0); send(mgrs_pkg::VAL_W'(7), 1'b0);
    send(mgrs_pkg::VAL_W'(7), 1'b1);
    send(mgrs_pkg::VAL_W'(9), 1'b0); send(mgrs_pkg::VAL_W'(10), 1'b0);
    send(mgrs_pkg::VAL_W'(1000), 1'b0);
    send(mgrs_pkg::VAL_W'(3), 1'b1);
    send(mgrs_pkg::VAL_W'(32'h2AAAAAAA), 1'b0); send(mgrs_pkg::VAL_W'(32'h55555555), 1'b1);
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < mgrs_pkg::MAX_ITEMS + 3; i++)
      send(rand_value(), i == mgrs_pkg::MAX_ITEMS + 2);
    sent = 0;
    while (sent < 660) begin
      int n;
      n = $urandom_range(0, 9) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
      calm = (sent > 200 && sent < 400);
      send_set(n);
      sent += n;
      if (sent > 450 && sent <= 510) begin
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end
    push <= 1'b0;
    calm = 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("max_adjacent_gap_radix_sort: match");
    else $display("max_adjacent_gap_radix_sort: mismatch");
    $finish;
  end

  initial begin
    #60000000;
    $display("max_adjacent_gap_radix_sort: mismatch");
    $finish;
  end
endmodule
